// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the rc4 engine: command codes, result kinds,
// sequencer state codes and the result record.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int KEY_LEN_W  = 9;
  localparam int STATE_W    = 4;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  // request commands
  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_SCHED = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // sequencer states
  localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STATE_W-1:0] ST_INIT  = 4'd1;
  localparam logic [STATE_W-1:0] ST_KRD_N = 4'd2;
  localparam logic [STATE_W-1:0] ST_KRD_J = 4'd3;
  localparam logic [STATE_W-1:0] ST_KWR_N = 4'd4;
  localparam logic [STATE_W-1:0] ST_KWR_J = 4'd5;
  localparam logic [STATE_W-1:0] ST_GRD_J = 4'd6;
  localparam logic [STATE_W-1:0] ST_GSWAP = 4'd7;
  localparam logic [STATE_W-1:0] ST_GWR_J = 4'd8;
  localparam logic [STATE_W-1:0] ST_EMIT  = 4'd9;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic  kind;
    byte_t data;
    logic  last;
  } res_t;

endpackage

// ===== rtl/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 engine: key byte store, key schedule and keystream generator built
// around one permutation RAM and one key RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel carries one request per transfer (valid/stall). A key-load
//   request writes the key RAM in the accepting cycle and gives no result. A
//   schedule request fills the permutation with identity, then does 256
//   swaps, clears i and j and returns one done result. A data request runs
//   read S[i], read S[j], write S[i] with read of S[t] and write S[j], then
//   gives its result; the permutation RAM has a single read port.
//   Requests are taken only while the sequencer is idle; in_stall is high
//   otherwise. The result sits in an output register, so the next request is
//   accepted while a result waits; when out_stall holds that register, a new
//   result waits in the sequencer until the register frees.
//   cfg_* writes key_length (always ready); write it only while idle.
//   Reset clears i, j and the handshake state and sets key_length to 16; the
//   permutation and key contents are undefined until a schedule or key load.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int KEY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_key_position,
  input  logic [7:0] in_value,
  input  logic       in_last_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_last_out,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_key_length
);

  localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] KEY_DEPTH_L = rc4_pkg::KEY_LEN_W'(KEY_DEPTH);

  logic [rc4_pkg::STATE_W-1:0] state_r, state_nxt;
  rc4_pkg::byte_t i_r, i_nxt;
  rc4_pkg::byte_t j_r, j_nxt;
  rc4_pkg::byte_t n_r, n_nxt;
  logic [KAW-1:0] kidx_r, kidx_nxt;
  rc4_pkg::byte_t si_r, si_nxt;
  rc4_pkg::byte_t sj_r, sj_nxt;
  rc4_pkg::byte_t t_r, t_nxt;
  rc4_pkg::byte_t val_r, val_nxt;
  logic           last_r, last_nxt;
  rc4_pkg::res_t  res_r, res_nxt;
  rc4_pkg::res_t  out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_length_r;

  logic           in_accept;
  logic           out_free;
  logic           out_load;
  logic           perm_we;
  rc4_pkg::byte_t perm_waddr, perm_wdata, perm_raddr, perm_rdata;
  logic           key_we;
  rc4_pkg::byte_t key_rdata;
  logic [rc4_pkg::KEY_LEN_W-1:0] eff_len;
  logic [rc4_pkg::KEY_LEN_W-1:0] kidx_inc;

  // state memories
  rc4_ram #(.WIDTH(rc4_pkg::BYTE_W), .DEPTH(rc4_pkg::PERM_DEPTH)) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  rc4_ram #(.WIDTH(rc4_pkg::BYTE_W), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_key_position[KAW-1:0]),
    .wdata (in_value),
    .raddr (kidx_r),
    .rdata (key_rdata)
  );

  // handshake
  assign in_stall  = (state_r != rc4_pkg::ST_IDLE);
  assign in_accept = in_valid && (state_r == rc4_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid    = out_valid_r;
  assign out_kind     = out_r.kind;
  assign out_out_byte = out_r.data;
  assign out_last_out = out_r.last;

  // key load: positions beyond the key RAM are dropped
  assign key_we = in_accept && (in_command == rc4_pkg::CMD_KEY)
                  && ({1'b0, in_key_position} < KEY_DEPTH_L);

  // effective key length and cyclic key index
  assign eff_len  = ((key_length_r == '0) || (key_length_r > KEY_DEPTH_L))
                    ? KEY_DEPTH_L : key_length_r;
  assign kidx_inc = rc4_pkg::KEY_LEN_W'(kidx_r) + 1'b1;

  // sequencer
  always_comb begin
    rc4_pkg::byte_t jn;
    rc4_pkg::byte_t tn;
    rc4_pkg::byte_t ks;
    rc4_pkg::res_t  res;

    jn  = '0;
    tn  = '0;
    ks  = '0;
    res = '0;

    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    kidx_nxt      = kidx_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_load      = 1'b0;
    perm_we       = 1'b0;
    perm_waddr    = i_r;
    perm_wdata    = '0;
    perm_raddr    = i_r;

    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_command)
            rc4_pkg::CMD_SCHED: begin
              n_nxt     = '0;
              state_nxt = rc4_pkg::ST_INIT;
            end
            rc4_pkg::CMD_DATA: begin
              i_nxt      = i_r + 8'd1;
              perm_raddr = i_r + 8'd1;
              val_nxt    = in_value;
              last_nxt   = in_last_in;
              state_nxt  = rc4_pkg::ST_GRD_J;
            end
            default: begin
            end
          endcase
        end
      end
      // identity fill
      rc4_pkg::ST_INIT: begin
        perm_we    = 1'b1;
        perm_waddr = n_r;
        perm_wdata = n_r;
        n_nxt      = n_r + 8'd1;
        if (n_r == 8'hFF) begin
          j_nxt     = '0;
          kidx_nxt  = '0;
          state_nxt = rc4_pkg::ST_KRD_N;
        end
      end
      // schedule swap: read S[n] and key byte
      rc4_pkg::ST_KRD_N: begin
        perm_raddr = n_r;
        state_nxt  = rc4_pkg::ST_KRD_J;
      end
      rc4_pkg::ST_KRD_J: begin
        jn         = j_r + perm_rdata + key_rdata;
        perm_raddr = jn;
        j_nxt      = jn;
        si_nxt     = perm_rdata;
        state_nxt  = rc4_pkg::ST_KWR_N;
      end
      rc4_pkg::ST_KWR_N: begin
        perm_we    = 1'b1;
        perm_waddr = n_r;
        perm_wdata = perm_rdata;
        state_nxt  = rc4_pkg::ST_KWR_J;
      end
      rc4_pkg::ST_KWR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = si_r;
        n_nxt      = n_r + 8'd1;
        kidx_nxt   = (kidx_inc >= eff_len) ? '0 : kidx_inc[KAW-1:0];
        if (n_r == 8'hFF) begin
          i_nxt     = '0;
          j_nxt     = '0;
          res_nxt   = '{kind: rc4_pkg::KIND_DONE, data: '0, last: 1'b0};
          state_nxt = rc4_pkg::ST_EMIT;
        end else begin
          state_nxt = rc4_pkg::ST_KRD_N;
        end
      end
      // generator: S[i] arrives, read S[j]
      rc4_pkg::ST_GRD_J: begin
        jn         = j_r + perm_rdata;
        perm_raddr = jn;
        j_nxt      = jn;
        si_nxt     = perm_rdata;
        state_nxt  = rc4_pkg::ST_GSWAP;
      end
      // write S[i] = S[j], read S[t] (old data on collision)
      rc4_pkg::ST_GSWAP: begin
        perm_we    = 1'b1;
        perm_waddr = i_r;
        perm_wdata = perm_rdata;
        tn         = si_r + perm_rdata;
        perm_raddr = tn;
        t_nxt      = tn;
        sj_nxt     = perm_rdata;
        state_nxt  = rc4_pkg::ST_GWR_J;
      end
      // write S[j] = S[i], forward swapped values into the keystream read
      rc4_pkg::ST_GWR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = si_r;
        if (t_r == i_r) begin
          ks = sj_r;
        end else if (t_r == j_r) begin
          ks = si_r;
        end else begin
          ks = perm_rdata;
        end
        res = '{kind: rc4_pkg::KIND_DATA, data: val_r ^ ks, last: last_r};
        if (out_free) begin
          out_load  = 1'b1;
          out_nxt   = res;
          state_nxt = rc4_pkg::ST_IDLE;
        end else begin
          res_nxt   = res;
          state_nxt = rc4_pkg::ST_EMIT;
        end
      end
      // hold a result until the output register frees
      rc4_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_nxt   = res_r;
          state_nxt = rc4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || out_load;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rc4_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      key_length_r <= rc4_pkg::KEY_LEN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      if (cfg_valid && cfg_ready) begin
        key_length_r <= cfg_key_length;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    kidx_r <= kidx_nxt;
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    t_r    <= t_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // checks
  a_idle_no_perm_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_IDLE) |-> !perm_we)
    else $error("permutation written while idle");

  a_done_clears_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_KWR_J && n_r == 8'hFF) |=> (i_r == '0 && j_r == '0))
    else $error("indexes not cleared after schedule");

  a_data_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_command == rc4_pkg::CMD_DATA)
      |=> (state_r == rc4_pkg::ST_GRD_J && i_r == $past(i_r) + 8'd1))
    else $error("data request did not start generator step");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over a held result");

endmodule
